### rtl/core/mch_pkg.sv
// Shared types, constants and CORDIC angle table for the magnetometer core.
`default_nettype none
package mch_pkg;

   localparam int CordicSteps = 16;
   localparam int GainFracBits = 12;
   localparam int AccWidth = 34;
   localparam int CordWidth = 42;

   typedef enum logic [1:0] {
      CMD_MEASURE = 2'd0,
      CMD_CALIB   = 2'd1,
      CMD_FINISH  = 2'd2,
      CMD_SPARE   = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      ST_MEASURED  = 2'd0,
      ST_SAMPLED   = 2'd1,
      ST_CAL_DONE  = 2'd2,
      ST_DEGEN     = 2'd3
   } status_type;

   localparam logic signed [15:0] OFFSET_X_RST = -16'sd89;
   localparam logic signed [15:0] OFFSET_Y_RST = -16'sd147;
   localparam logic signed [15:0] OFFSET_Z_RST = 16'sd71;
   localparam logic [15:0] GAIN_ONE   = 16'd4096;
   localparam logic [15:0] GAIN_Y_RST = 16'd4055;
   localparam logic [15:0] GAIN_Z_RST = 16'd4342;

   localparam logic signed [AccWidth-1:0] HALF_TURN = 34'sd1179648000;

   // Divider request/response between sequencer and divider.
   typedef struct packed {
      logic        start;
      logic        neg;
      logic [30:0] dividend;
      logic [16:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [30:0] quotient;
   } div_rsp_type;

   function automatic logic [AccWidth-1:0] atan_lut(input logic [4:0] i);
      logic [AccWidth-1:0] v;
      case (i)
         5'd0:  v = 34'd294912000;
         5'd1:  v = 34'd174096719;
         5'd2:  v = 34'd91987925;
         5'd3:  v = 34'd46694507;
         5'd4:  v = 34'd23437865;
         5'd5:  v = 34'd11730358;
         5'd6:  v = 34'd5866610;
         5'd7:  v = 34'd2933484;
         5'd8:  v = 34'd1466764;
         5'd9:  v = 34'd733385;
         5'd10: v = 34'd366693;
         5'd11: v = 34'd183346;
         5'd12: v = 34'd91673;
         5'd13: v = 34'd45837;
         5'd14: v = 34'd22918;
         5'd15: v = 34'd11459;
         5'd16: v = 34'd5730;
         5'd17: v = 34'd2865;
         5'd18: v = 34'd1432;
         5'd19: v = 34'd716;
         5'd20: v = 34'd358;
         5'd21: v = 34'd179;
         5'd22: v = 34'd90;
         5'd23: v = 34'd45;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

### rtl/core/magnetometer_calibrate_and_heading_core.sv
// Top level: sequencer, trackers, corrections and a shared CORDIC datapath.
// From input accept to result valid: measure runs three scaling divides, the branch,
// three multiply steps and three CORDIC runs; calibrate runs the three scaling divides and
// the branch; finish adds two gain divides. One item at a time, set by the shared
// bit-serial divider and the single CORDIC stage; the result waits in an output register
// and the next word is accepted from the cycle after it is taken.
// Reset (synchronous) restores divisor 1, default offsets and gains, zero trackers.
`default_nettype none
module magnetometer_calibrate_and_heading_core (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [55:0] req_tdata,   // cmd[1:0], raw_x, raw_y, raw_z, zero pad
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [127:0] rsp_tdata,  // status, corr x,y,z, heading_xy, angle_xz, angle_yz, pad
   input  wire         csr_valid,
   output logic        csr_ready,
   input  wire  [12:0] csr_data
);
   import mch_pkg::*;

   typedef enum logic [9:0] {
      S_IDLE   = 10'b0000000001,
      S_SDIV   = 10'b0000000010,
      S_SWAIT  = 10'b0000000100,
      S_BRANCH = 10'b0000001000,
      S_FDIV   = 10'b0000010000,
      S_FWAIT  = 10'b0000100000,
      S_MUL    = 10'b0001000000,
      S_CINIT  = 10'b0010000000,
      S_CSTEP  = 10'b0100000000,
      S_CDONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic [12:0] div_ff, div_in;
   logic [1:0]  cmd_ff, cmd_in;
   logic signed [15:0] raw_ff [3];
   logic signed [15:0] raw_in [3];
   logic signed [15:0] s_ff [3];
   logic signed [15:0] s_in [3];
   logic signed [15:0] off_ff [3];
   logic signed [15:0] off_in [3];
   logic [15:0] gain_ff [3];
   logic [15:0] gain_in [3];
   logic signed [15:0] max_ff [3];
   logic signed [15:0] max_in [3];
   logic signed [15:0] min_ff [3];
   logic signed [15:0] min_in [3];
   logic signed [CordWidth-1:0] c_ff [3];
   logic signed [CordWidth-1:0] c_in [3];
   logic [1:0]  k_ff, k_in;
   logic [4:0]  it_ff, it_in;
   logic signed [CordWidth-1:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [AccWidth-1:0]  acc_ff, acc_in;
   logic        zero_ff, zero_in;
   logic [15:0] ang_ff [3];
   logic [15:0] ang_in [3];
   logic        degen_ff, degen_in;
   logic        ovalid_ff, ovalid_in;
   logic [127:0] odata_ff, odata_in;

   div_req_type dreq;
   div_rsp_type drsp;

   mch_divider u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // shared multiply operands
   logic signed [16:0] mdiff;
   logic signed [34:0] mprod;
   logic signed [34:0] mabs;
   logic signed [CordWidth-1:0] mq;
   logic signed [CordWidth-1:0] dx, dy;
   logic signed [AccWidth-1:0]  rnd;
   logic signed [AccWidth-1:0]  r1;
   logic signed [16:0] rng_x, rng_y, rng_z, rng_k;
   logic signed [CordWidth-1:0] ox, oy;
   logic signed [23:0] sat [3];
   logic [15:0] q16;

   assign req_tready = (state_ff == S_IDLE) && !ovalid_ff;
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = odata_ff;

   always_comb begin
      // pick CORDIC operand pair by angle index
      unique case (k_ff)
         2'd0:    begin ox = c_ff[0]; oy = c_ff[1]; end
         2'd1:    begin ox = c_ff[0]; oy = c_ff[2]; end
         default: begin ox = c_ff[1]; oy = c_ff[2]; end
      endcase
   end

   always_comb begin
      state_in  = state_ff;
      div_in    = div_ff;
      cmd_in    = cmd_ff;
      raw_in    = raw_ff;
      s_in      = s_ff;
      off_in    = off_ff;
      gain_in   = gain_ff;
      max_in    = max_ff;
      min_in    = min_ff;
      c_in      = c_ff;
      k_in      = k_ff;
      it_in     = it_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      acc_in    = acc_ff;
      zero_in   = zero_ff;
      ang_in    = ang_ff;
      degen_in  = degen_ff;
      ovalid_in = ovalid_ff;
      odata_in  = odata_ff;
      dreq      = '0;

      mdiff = 17'(s_ff[k_ff]) - 17'(off_ff[k_ff]);
      mprod = 35'(mdiff) * $signed({19'd0, gain_ff[k_ff]});
      mabs  = mprod[34] ? -mprod : mprod;
      mq    = CordWidth'(mabs >>> (GainFracBits - 4));
      if (mprod[34]) mq = -mq;

      dx = cy_ff >>> it_ff;
      dy = cx_ff >>> it_ff;
      rnd = acc_ff + AccWidth'(32768);
      r1  = rnd >>> 16;

      rng_x = 17'(max_ff[0]) - 17'(min_ff[0]);
      rng_y = 17'(max_ff[1]) - 17'(min_ff[1]);
      rng_z = 17'(max_ff[2]) - 17'(min_ff[2]);
      rng_k = (k_ff == 2'd1) ? rng_y : rng_z;
      q16 = 16'hFFFF;

      for (int j = 0; j < 3; j++) begin
         sat[j] = (c_ff[j] > 42'sd8388607) ? 24'h7FFFFF :
                  (c_ff[j] < -42'sd8388608) ? 24'h800000 : c_ff[j][23:0];
      end

      if (rsp_tvalid && rsp_tready) ovalid_in = 1'b0;
      if (csr_valid && csr_ready) div_in = csr_data;

      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in    = req_tdata[1:0];
               raw_in[0] = req_tdata[17:2];
               raw_in[1] = req_tdata[33:18];
               raw_in[2] = req_tdata[49:34];
               k_in      = 2'd0;
               state_in  = S_SDIV;
            end
         end
         S_SDIV: begin
            dreq.start    = 1'b1;
            dreq.neg      = raw_ff[k_ff][15];
            dreq.dividend = 31'(raw_ff[k_ff][15] ? -17'(raw_ff[k_ff]) : 17'(raw_ff[k_ff]));
            dreq.divisor  = (div_ff == 13'd0) ? 17'd1 : 17'(div_ff);
            state_in      = S_SWAIT;
         end
         S_SWAIT: begin
            if (drsp.done) begin
               s_in[k_ff] = drsp.quotient[15:0];
               if (k_ff == 2'd2) begin
                  k_in = 2'd0;
                  state_in = S_BRANCH;
               end else begin
                  k_in = k_ff + 2'd1;
                  state_in = S_SDIV;
               end
            end
         end
         S_BRANCH: begin
            if (cmd_ff == CMD_CALIB) begin
               for (int j = 0; j < 3; j++) begin
                  if (s_ff[j] > max_ff[j]) max_in[j] = s_ff[j];
                  if (s_ff[j] < min_ff[j]) min_in[j] = s_ff[j];
               end
               odata_in  = {126'd0, ST_SAMPLED};
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
            end else if (cmd_ff == CMD_FINISH) begin
               degen_in = (rng_y == 17'd0) || (rng_z == 17'd0);
               k_in     = 2'd1;
               state_in = S_FDIV;
            end else begin
               k_in     = 2'd0;
               state_in = S_MUL;
            end
         end
         S_FDIV: begin
            dreq.start    = 1'b1;
            dreq.neg      = 1'b0;
            dreq.dividend = {rng_x[16:0], 14'd0} >> (14 - GainFracBits);
            dreq.divisor  = (rng_k == 17'd0) ? 17'd1 : rng_k;
            state_in      = S_FWAIT;
         end
         S_FWAIT: begin
            if (drsp.done) begin
               // keep every gain on a degenerate range
               if (!degen_ff) begin
                  gain_in[k_ff] = (|drsp.quotient[30:16]) ? q16 : drsp.quotient[15:0];
               end
               if (k_ff == 2'd2) begin
                  for (int j = 0; j < 3; j++) begin
                     // offset = (max+min)/2 toward zero
                     off_in[j] = 16'(((17'(max_ff[j]) + 17'(min_ff[j]))
                        + 17'((17'(max_ff[j]) + 17'(min_ff[j])) < 0)) >>> 1);
                     max_in[j] = '0;
                     min_in[j] = '0;
                  end
                  if (degen_ff) begin
                     odata_in   = {126'd0, ST_DEGEN};
                  end else begin
                     gain_in[0] = GAIN_ONE;
                     odata_in   = {126'd0, ST_CAL_DONE};
                  end
                  ovalid_in = 1'b1;
                  state_in  = S_IDLE;
               end else begin
                  k_in = k_ff + 2'd1;
                  state_in = S_FDIV;
               end
            end
         end
         S_MUL: begin
            c_in[k_ff] = mq;
            if (k_ff == 2'd2) begin
               k_in = 2'd0;
               state_in = S_CINIT;
            end else begin
               k_in = k_ff + 2'd1;
            end
         end
         S_CINIT: begin
            zero_in = (ox == 0) && (oy == 0);
            it_in   = 5'd0;
            if (ox < 0) begin
               acc_in = (oy >= 0) ? HALF_TURN : -HALF_TURN;
               cx_in  = -ox;
               cy_in  = -oy;
            end else begin
               acc_in = '0;
               cx_in  = ox;
               cy_in  = oy;
            end
            state_in = S_CSTEP;
         end
         S_CSTEP: begin
            if (cy_ff > 0) begin
               cx_in  = cx_ff + dx;
               cy_in  = cy_ff - dy;
               acc_in = acc_ff + $signed(atan_lut(it_ff));
            end else begin
               cx_in  = cx_ff - dx;
               cy_in  = cy_ff + dy;
               acc_in = acc_ff - $signed(atan_lut(it_ff));
            end
            it_in = it_ff + 5'd1;
            if (it_ff == 5'(CordicSteps - 1)) state_in = S_CDONE;
         end
         S_CDONE: begin
            // wrap into (-18000, 18000]
            if (zero_ff) begin
               ang_in[k_ff] = '0;
            end else if (r1 > 34'sd18000) begin
               ang_in[k_ff] = 16'(r1 - 34'sd36000);
            end else if (r1 <= -34'sd18000) begin
               ang_in[k_ff] = 16'(r1 + 34'sd36000);
            end else begin
               ang_in[k_ff] = 16'(r1);
            end
            if (k_ff == 2'd0 && !zero_ff && ang_in[0][15]) begin
               ang_in[0] = ang_in[0] + 16'd36000;
            end
            if (k_ff == 2'd2) begin
               odata_in = {6'd0, ang_in[2], ang_in[1], ang_in[0],
                           sat[2], sat[1], sat[0], ST_MEASURED};
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
            end else begin
               k_in = k_ff + 2'd1;
               state_in = S_CINIT;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         div_ff    <= 13'd1;
         ovalid_ff <= 1'b0;
         off_ff[0] <= OFFSET_X_RST;
         off_ff[1] <= OFFSET_Y_RST;
         off_ff[2] <= OFFSET_Z_RST;
         gain_ff[0] <= GAIN_ONE;
         gain_ff[1] <= GAIN_Y_RST;
         gain_ff[2] <= GAIN_Z_RST;
         for (int j = 0; j < 3; j++) begin
            max_ff[j] <= '0;
            min_ff[j] <= '0;
         end
      end else begin
         state_ff  <= state_in;
         div_ff    <= div_in;
         ovalid_ff <= ovalid_in;
         off_ff    <= off_in;
         gain_ff   <= gain_in;
         max_ff    <= max_in;
         min_ff    <= min_in;
      end
      cmd_ff   <= cmd_in;
      raw_ff   <= raw_in;
      s_ff     <= s_in;
      c_ff     <= c_in;
      k_ff     <= k_in;
      it_ff    <= it_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      acc_ff   <= acc_in;
      zero_ff  <= zero_in;
      ang_ff   <= ang_in;
      degen_ff <= degen_in;
      odata_ff <= odata_in;
   end

   // a result word holds until taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word dropped while stalled");
   // no new item while a result is pending
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready)
      else $error("input accepted with result pending");
   // the x trackers bracket zero
   assert property (@(posedge clock) disable iff (reset)
      !max_ff[0][15] && (min_ff[0][15] || min_ff[0] == 16'sd0))
      else $error("tracker lost zero bracket");
endmodule
`default_nettype wire

### rtl/core/mch_divider.sv
// Restoring divider, one quotient bit per cycle, sign applied at the end.
`default_nettype none
module mch_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  mch_pkg::div_req_type  req,
   output mch_pkg::div_rsp_type  rsp
);
   import mch_pkg::*;

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [30:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [16:0] den_ff, den_in;
   logic        neg_ff, neg_in;
   logic        done_ff, done_in;
   logic [17:0] trial;

   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[30]} - {1'b0, den_ff};
      if (req.start) begin
         busy_in = 1'b1;
         cnt_in  = 5'd0;
         quo_in  = req.dividend;
         rem_in  = '0;
         den_in  = req.divisor;
         neg_in  = req.neg;
      end else if (busy_ff) begin
         // shift in next dividend bit, subtract when it fits
         if (!trial[17]) begin
            rem_in = trial[16:0];
            quo_in = {quo_ff[29:0], 1'b1};
         end else begin
            rem_in = {rem_ff[15:0], quo_ff[30]};
            quo_in = {quo_ff[29:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd30) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign rsp.done     = done_ff;
   assign rsp.quotient = neg_ff ? (~quo_ff + 31'd1) : quo_ff;
endmodule
`default_nettype wire

### tb/sv/tb.sv
// Testbench for the magnetometer calibration and heading core: streams samples, checks every result.
`timescale 1ns / 1ps
module tb;
   import mch_pkg::*;

   // last member sits in the lowest bits
   typedef struct packed {
      logic signed [15:0] rz;
      logic signed [15:0] ry;
      logic signed [15:0] rx;
      logic [1:0]         cmd;
   } sample_t;

   typedef struct packed {
      logic signed [15:0] ayz;
      logic signed [15:0] axz;
      logic [15:0]        hxy;
      logic signed [23:0] cz;
      logic signed [23:0] cy;
      logic signed [23:0] cx;
      logic [1:0]         status;
   } heading_t;

   localparam longint Q4Max = 64'sd8388607;
   localparam longint Q4Min = -64'sd8388608;
   localparam int WatchLimit = 20000;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [55:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [127:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [12:0] csr_data = 13'd1;

   magnetometer_calibrate_and_heading_core u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   // predictor state
   longint div_now;
   longint offs[3];
   longint gains[3];
   longint maxs[3];
   longint mins[3];

   sample_t  pending[$];
   heading_t expected[$];
   int errors = 0;
   int idle_cycles = 0;
   int hold_off = 0;
   bit pause_tx = 0;
   bit req_taken = 0;
   int gap = 0;
   int burst = 0;

   initial forever #6 clock = ~clock;

   function automatic longint floor_shift(longint v, int s);
      if (v >= 0) return v >>> s;
      return -(((-v) - 1) >>> s) - 1;
   endfunction

   function automatic longint sat_gain(longint g);
      return g > 65535 ? 65535 : g;
   endfunction

   function automatic longint cordic_centideg(longint x, longint y);
      longint acc = 0;
      longint r, dx, dy;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
         acc = (y >= 0) ? 18000 * 65536 : -18000 * 65536;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CordicSteps; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (y > 0) begin
            x += dx; y -= dy; acc += longint'(atan_lut(i[4:0]));
         end else begin
            x -= dx; y += dy; acc -= longint'(atan_lut(i[4:0]));
         end
      end
      r = floor_shift(acc + 32768, 16);
      while (r > 18000) r -= 36000;
      while (r <= -18000) r += 36000;
      return r;
   endfunction

   function automatic heading_t predict_heading(sample_t it);
      heading_t h = '0;
      longint s[3], c[3], p, q, sat, rxr, ryr, rzr, a;
      s[0] = longint'(it.rx) / div_now;
      s[1] = longint'(it.ry) / div_now;
      s[2] = longint'(it.rz) / div_now;
      if (it.cmd == CMD_CALIB) begin
         for (int k = 0; k < 3; k++) begin
            if (s[k] > maxs[k]) maxs[k] = s[k];
            if (s[k] < mins[k]) mins[k] = s[k];
         end
         h.status = ST_SAMPLED;
      end else if (it.cmd == CMD_FINISH) begin
         rxr = maxs[0] - mins[0];
         ryr = maxs[1] - mins[1];
         rzr = maxs[2] - mins[2];
         for (int k = 0; k < 3; k++) offs[k] = (maxs[k] + mins[k]) / 2;
         if (ryr == 0 || rzr == 0) h.status = ST_DEGEN;
         else begin
            gains[0] = GAIN_ONE;
            gains[1] = sat_gain((rxr << GainFracBits) / ryr);
            gains[2] = sat_gain((rxr << GainFracBits) / rzr);
            h.status = ST_CAL_DONE;
         end
         for (int k = 0; k < 3; k++) begin maxs[k] = 0; mins[k] = 0; end
      end else begin
         for (int k = 0; k < 3; k++) begin
            p = (s[k] - offs[k]) * gains[k];
            q = p >= 0 ? (p >>> (GainFracBits - 4)) : -((-p) >>> (GainFracBits - 4));
            c[k] = q;
         end
         sat = c[0] > Q4Max ? Q4Max : (c[0] < Q4Min ? Q4Min : c[0]); h.cx = sat[23:0];
         sat = c[1] > Q4Max ? Q4Max : (c[1] < Q4Min ? Q4Min : c[1]); h.cy = sat[23:0];
         sat = c[2] > Q4Max ? Q4Max : (c[2] < Q4Min ? Q4Min : c[2]); h.cz = sat[23:0];
         a = cordic_centideg(c[0], c[1]);
         if (a < 0) a += 36000;
         h.hxy = a[15:0];
         a = cordic_centideg(c[0], c[2]); h.axz = a[15:0];
         a = cordic_centideg(c[1], c[2]); h.ayz = a[15:0];
         h.status = ST_MEASURED;
      end
      return h;
   endfunction

   // driver: bursts and gaps, holds the word until accepted
   always @(negedge clock) begin
      if (!reset) begin
         if (req_tvalid && !req_taken) begin
         end else if (!pause_tx && pending.size() > 0 && gap == 0) begin
            req_tvalid <= 1;
            req_tdata <= 56'(pending.pop_front());
            if (burst == 0) begin
               burst = $urandom_range(1, 12);
               gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 300);
            end else burst--;
         end else begin
            req_tvalid <= 0;
            if (gap > 0) gap--;
         end
      end
   end

   // receiver: own stall pattern and long hold-off
   always @(negedge clock) begin
      if (!reset) begin
         if (hold_off > 0) begin
            rsp_tready <= 0;
            hold_off--;
         end else rsp_tready <= ($urandom_range(0, 7) < 5) || ($urandom_range(0, 1) == 0);
      end
   end

   // predict on acceptance, check results
   always @(posedge clock) begin
      heading_t got, exp_h;
      bit took;
      took = 0;
      req_taken = req_tvalid && req_tready;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            div_now = (csr_data == 0) ? 1 : csr_data;
            took = 1;
         end
         if (req_tvalid && req_tready) begin
            expected.push_back(predict_heading(sample_t'(req_tdata[49:0])));
            took = 1;
         end
         if (rsp_tvalid && rsp_tready) begin
            took = 1;
            got = heading_t'(rsp_tdata[$bits(heading_t)-1:0]);
            if (expected.size() == 0) begin
               $error("result word with no expectation");
               errors++;
            end else begin
               exp_h = expected.pop_front();
               if (got.status !== exp_h.status) begin
                  $error("status exp %0d got %0d", exp_h.status, got.status); errors++; end
               if (got.cx !== exp_h.cx) begin
                  $error("corrected_x exp %0d got %0d", exp_h.cx, got.cx); errors++; end
               if (got.cy !== exp_h.cy) begin
                  $error("corrected_y exp %0d got %0d", exp_h.cy, got.cy); errors++; end
               if (got.cz !== exp_h.cz) begin
                  $error("corrected_z exp %0d got %0d", exp_h.cz, got.cz); errors++; end
               if (got.hxy !== exp_h.hxy) begin
                  $error("heading_xy exp %0d got %0d", exp_h.hxy, got.hxy); errors++; end
               if (got.axz !== exp_h.axz) begin
                  $error("angle_xz exp %0d got %0d", exp_h.axz, got.axz); errors++; end
               if (got.ayz !== exp_h.ayz) begin
                  $error("angle_yz exp %0d got %0d", exp_h.ayz, got.ayz); errors++; end
            end
         end
         if (took) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > WatchLimit) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   function automatic sample_t pack_sample(logic [1:0] c, int x, int y, int z);
      sample_t it;
      it.cmd = c; it.rx = x[15:0]; it.ry = y[15:0]; it.rz = z[15:0];
      return it;
   endfunction

   function automatic int rand_axis();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 1) ? 32767 : -32768;
         1: return $signed($urandom_range(0, 200)) - 100;
         default: return $signed($urandom_range(0, 65535)) - 32768;
      endcase
   endfunction

   task automatic drain();
      wait (pending.size() == 0 && !req_tvalid);
      wait (expected.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_divisor(logic [12:0] v);
      @(negedge clock);
      csr_valid <= 1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic push_cal_run(int n);
      for (int i = 0; i < n; i++)
         pending.push_back(pack_sample(CMD_CALIB, rand_axis(), rand_axis(), rand_axis()));
      pending.push_back(pack_sample(CMD_FINISH, rand_axis(), rand_axis(), rand_axis()));
   endtask

   initial begin
      logic [12:0] divs[6];
      int next_pause;
      div_now = 1;
      offs[0] = OFFSET_X_RST; offs[1] = OFFSET_Y_RST; offs[2] = OFFSET_Z_RST;
      gains[0] = GAIN_ONE; gains[1] = GAIN_Y_RST; gains[2] = GAIN_Z_RST;
      for (int k = 0; k < 3; k++) begin maxs[k] = 0; mins[k] = 0; end
      divs[0] = 13'd4096; divs[1] = 13'd0; divs[2] = 13'd3;
      divs[3] = 13'd1; divs[4] = 13'd8191; divs[5] = 13'd17;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // directed: extremes, zero vectors, every command, degenerate finish
      pending.push_back(pack_sample(CMD_MEASURE, 0, 0, 0));
      pending.push_back(pack_sample(CMD_MEASURE, -89, -147, 71));
      pending.push_back(pack_sample(CMD_MEASURE, 32767, 32767, 32767));
      pending.push_back(pack_sample(CMD_MEASURE, -32768, -32768, -32768));
      pending.push_back(pack_sample(CMD_MEASURE, -32768, 32767, -1));
      pending.push_back(pack_sample(CMD_SPARE, 1000, -1000, 0));
      pending.push_back(pack_sample(CMD_MEASURE, -1000, -147, 71));
      pending.push_back(pack_sample(CMD_FINISH, 5, 5, 5));
      pending.push_back(pack_sample(CMD_CALIB, 32767, 0, 0));
      pending.push_back(pack_sample(CMD_FINISH, 0, 0, 0));
      pending.push_back(pack_sample(CMD_CALIB, 32767, 1, -1));
      pending.push_back(pack_sample(CMD_CALIB, -32768, -1, 1));
      pending.push_back(pack_sample(CMD_FINISH, 0, 0, 0));
      pending.push_back(pack_sample(CMD_MEASURE, 32767, -32768, 12345));
      pending.push_back(pack_sample(CMD_CALIB, 10, 32767, -32768));
      pending.push_back(pack_sample(CMD_CALIB, -10, -32768, 32767));
      pending.push_back(pack_sample(CMD_FINISH, 0, 0, 0));
      pending.push_back(pack_sample(CMD_MEASURE, 20000, -3000, 500));
      drain();

      // receiver holds off while the sender keeps offering
      hold_off = 2000;
      for (int i = 0; i < 8; i++)
         pending.push_back(pack_sample(CMD_MEASURE, rand_axis(), rand_axis(), rand_axis()));
      drain();

      for (int ph = 0; ph < 6; ph++) begin
         write_divisor(divs[ph]);
         next_pause = 60;
         for (int n = 0; n < 170; ) begin
            if ($urandom_range(0, 2) == 0) begin
               push_cal_run($urandom_range(1, 6));
               n += 4;
            end else begin
               pending.push_back(pack_sample(2'($urandom_range(0, 3)),
                                             rand_axis(), rand_axis(), rand_axis()));
               n++;
            end
            if (n >= next_pause) begin
               next_pause += 60;
               // let the sender work, then pause it until the block has caught up
               wait (pending.size() <= 10);
               pause_tx = 1;
               wait (expected.size() == 0 && !req_tvalid);
               pause_tx = 0;
            end
         end
         drain();
      end

      if (errors == 0 && expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule

### magnetometer_calibrate_and_heading_core.f
rtl/core/mch_pkg.sv
rtl/core/mch_divider.sv
rtl/core/magnetometer_calibrate_and_heading_core.sv
tb/sv/tb.sv
